// ----- hdl/nps_pkg.sv -----
// Shared types and constants for the non-preemptive priority scheduler.
// No dependencies; imported by every module of the block.
package nps_pkg;

	// Field widths of a job and of a dispatch result
	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 8;
	localparam int TIME_W = 21;
	localparam int JIDX_W = 4;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE
	} nps_state_t;

	// Control from the sequencer to the pick unit
	typedef struct packed {
		logic clr;       // start of a scan: forget both candidates
		logic vld;       // a stored job is presented this cycle
		logic finished;  // presented job already ran
	} pick_ctl_t;

endpackage

// ----- hdl/nps_job_mem.sv -----
// Job store: arrival, burst and priority for each loaded job.
// One write port (loading), one registered read port (scan). Uses nps_pkg.
module nps_job_mem
	import nps_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [ARR_W-1:0] wr_arr,
	input  logic [BUR_W-1:0] wr_bur,
	input  logic [PRI_W-1:0] wr_pri,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [ARR_W-1:0] rd_arr,
	output logic [BUR_W-1:0] rd_bur,
	output logic [PRI_W-1:0] rd_pri
);

	localparam int WORD_W = ARR_W + BUR_W + PRI_W;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_word_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_arr, wr_bur, wr_pri};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	assign rd_arr = rd_word_q[WORD_W-1 -: ARR_W];
	assign rd_bur = rd_word_q[BUR_W+PRI_W-1 -: BUR_W];
	assign rd_pri = rd_word_q[PRI_W-1:0];

endmodule

// ----- hdl/nps_pick_unit.sv -----
// Pick unit: compares one stored job per cycle against the running best.
// Tracks the best arrived job and the earliest pending job. Uses nps_pkg.
module nps_pick_unit
	import nps_pkg::*;
#(
	parameter int AW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pick_ctl_t         ctl,
	input  logic [TIME_W-1:0] clock_now,
	input  logic [AW-1:0]     idx,
	input  logic [ARR_W-1:0]  arr,
	input  logic [BUR_W-1:0]  bur,
	input  logic [PRI_W-1:0]  pri,
	output logic              have_a,
	output logic [AW-1:0]     a_idx,
	output logic [ARR_W-1:0]  a_arr,
	output logic [BUR_W-1:0]  a_bur,
	output logic              have_e,
	output logic [AW-1:0]     e_idx,
	output logic [ARR_W-1:0]  e_arr,
	output logic [BUR_W-1:0]  e_bur
);

	logic             have_a_q, have_e_q;
	logic [AW-1:0]    a_idx_q, e_idx_q;
	logic [ARR_W-1:0] a_arr_q, e_arr_q;
	logic [BUR_W-1:0] a_bur_q, e_bur_q;
	logic [PRI_W-1:0] a_pri_q, e_pri_q;
	logic             arrived, take_a, take_e;

	// Arrived candidate: lowest priority value, then earlier arrival.
	// Earliest candidate: earliest arrival, then lowest priority value.
	// Strict compares keep the lower index on a full tie.
	always_comb begin
		arrived = (TIME_W'(arr) <= clock_now);
		take_a  = ctl.vld && !ctl.finished && arrived &&
			(!have_a_q || (pri < a_pri_q) || ((pri == a_pri_q) && (arr < a_arr_q)));
		take_e  = ctl.vld && !ctl.finished &&
			(!have_e_q || (arr < e_arr_q) || ((arr == e_arr_q) && (pri < e_pri_q)));
	end

	// candidate flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_a_q <= 1'b0;
			have_e_q <= 1'b0;
		end else if (ctl.clr) begin
			have_a_q <= 1'b0;
			have_e_q <= 1'b0;
		end else begin
			if (take_a) have_a_q <= 1'b1;
			if (take_e) have_e_q <= 1'b1;
		end
	end

	// candidate payload
	always_ff @(posedge clk) begin
		if (take_a && !ctl.clr) begin
			a_idx_q <= idx;
			a_arr_q <= arr;
			a_bur_q <= bur;
			a_pri_q <= pri;
		end
		if (take_e && !ctl.clr) begin
			e_idx_q <= idx;
			e_arr_q <= arr;
			e_bur_q <= bur;
			e_pri_q <= pri;
		end
	end

	assign have_a = have_a_q;
	assign a_idx  = a_idx_q;
	assign a_arr  = a_arr_q;
	assign a_bur  = a_bur_q;
	assign have_e = have_e_q;
	assign e_idx  = e_idx_q;
	assign e_arr  = e_arr_q;
	assign e_bur  = e_bur_q;

endmodule

// ----- hdl/nonpreemptive_priority_scheduler.sv -----
// Non-preemptive priority scheduler, top level. Uses nps_pkg, nps_job_mem, nps_pick_unit.
// Loading: one job per cycle while job_stall is low; a job that is neither last nor fills
// the store causes no result. Per dispatch: a scan of all N jobs in the set through the
// job store read port, a drain state for the registered read, then a write state that waits
// while the result register is full. Results leave in dispatch order; job is stalled meanwhile.
// Reset clears job count, clock, finished flags and handshake state; the store is not cleared.
module nonpreemptive_priority_scheduler
	import nps_pkg::*;
#(
	parameter int MAX_JOBS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// job requests
	input  logic              job_valid,
	output logic              job_stall,
	input  logic [ARR_W-1:0]  arrival_time,
	input  logic [BUR_W-1:0]  burst_time,
	input  logic [PRI_W-1:0]  priority_level,
	input  logic              last_job,
	// dispatch results
	output logic              res_valid,
	input  logic              res_stall,
	output logic [JIDX_W-1:0] job_index,
	output logic [TIME_W-1:0] start_time,
	output logic [TIME_W-1:0] completion_time,
	output logic [TIME_W-1:0] turnaround_time,
	output logic [TIME_W-1:0] waiting_time,
	output logic              last_result
);

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_JOBS);

	nps_state_t state_q, state_d;

	logic [CW-1:0]       count_q, done_q, rd_idx_q;
	logic [TIME_W-1:0]   clock_q;
	logic [MAX_JOBS-1:0] fin_q;
	logic [IW-1:0]       idx_s1;
	logic                rd_v_s1;
	logic                res_valid_q;

	logic                load_fire, start_sched, write_fire, scan_end, out_free;
	logic [CW-1:0]       count_inc;

	logic [ARR_W-1:0]    m_arr;
	logic [BUR_W-1:0]    m_bur;
	logic [PRI_W-1:0]    m_pri;
	pick_ctl_t           pick_ctl;

	logic                have_a, have_e;
	logic [IW-1:0]       a_idx, e_idx, sel_idx;
	logic [ARR_W-1:0]    a_arr, e_arr, sel_arr;
	logic [BUR_W-1:0]    a_bur, e_bur, sel_bur;
	logic [TIME_W-1:0]   t_start, t_fin, t_turn, t_wait;
	logic                is_last;

	logic [JIDX_W-1:0]   job_index_q;
	logic [TIME_W-1:0]   start_q, fin_time_q, turn_q, wait_q;
	logic                last_q;

	// job store
	nps_job_mem #(
		.DEPTH (MAX_JOBS),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (load_fire),
		.wr_addr (count_q[IW-1:0]),
		.wr_arr  (arrival_time),
		.wr_bur  (burst_time),
		.wr_pri  (priority_level),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (rd_idx_q[IW-1:0]),
		.rd_arr  (m_arr),
		.rd_bur  (m_bur),
		.rd_pri  (m_pri)
	);

	// shared compare unit
	always_comb begin
		pick_ctl.clr      = (state_q == ST_SCAN) && (rd_idx_q == '0);
		pick_ctl.vld      = rd_v_s1;
		pick_ctl.finished = fin_q[idx_s1];
	end

	nps_pick_unit #(
		.AW (IW)
	) u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pick_ctl),
		.clock_now (clock_q),
		.idx       (idx_s1),
		.arr       (m_arr),
		.bur       (m_bur),
		.pri       (m_pri),
		.have_a    (have_a),
		.a_idx     (a_idx),
		.a_arr     (a_arr),
		.a_bur     (a_bur),
		.have_e    (have_e),
		.e_idx     (e_idx),
		.e_arr     (e_arr),
		.e_bur     (e_bur)
	);

	// Dispatch decision: an arrived job runs now, else time jumps to the earliest arrival
	always_comb begin
		sel_idx = have_a ? a_idx : e_idx;
		sel_arr = have_a ? a_arr : e_arr;
		sel_bur = have_a ? a_bur : e_bur;
		t_start = have_a ? clock_q : TIME_W'(e_arr);
		t_fin   = t_start + TIME_W'(sel_bur);
		t_wait  = t_start - TIME_W'(sel_arr);
		t_turn  = t_fin - TIME_W'(sel_arr);
		is_last = (CW'(done_q + CW'(1)) == count_q);
	end

	// Sequencer: next state and strobes
	always_comb begin
		count_inc   = CW'(count_q + CW'(1));
		load_fire   = job_valid && (state_q == ST_IDLE);
		start_sched = last_job || (count_inc == FULL_CNT);
		scan_end    = (rd_idx_q == CW'(count_q - CW'(1)));
		out_free    = !res_valid_q || !res_stall;
		write_fire  = (state_q == ST_WRITE) && out_free;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load_fire && start_sched) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) state_d = is_last ? ST_IDLE : ST_SCAN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Job count, clock, finished flags, scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= '0;
			rd_idx_q <= '0;
			clock_q  <= '0;
			fin_q    <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			if (load_fire) begin
				count_q <= count_inc;
				done_q  <= '0;
				clock_q <= '0;
			end
			if (state_q == ST_SCAN) begin
				rd_idx_q <= scan_end ? '0 : CW'(rd_idx_q + CW'(1));
			end
			if (write_fire) begin
				if (is_last) begin
					count_q <= '0;
					done_q  <= '0;
					clock_q <= '0;
					fin_q   <= '0;
				end else begin
					done_q         <= CW'(done_q + CW'(1));
					clock_q        <= t_fin;
					fin_q[sel_idx] <= 1'b1;
				end
			end
		end
	end

	// read pipeline tag
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IW-1:0];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (write_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_fire) begin
			job_index_q <= JIDX_W'(sel_idx);
			start_q     <= t_start;
			fin_time_q  <= t_fin;
			turn_q      <= t_turn;
			wait_q      <= t_wait;
			last_q      <= is_last;
		end
	end

	assign job_stall       = (state_q != ST_IDLE);
	assign res_valid       = res_valid_q;
	assign job_index       = job_index_q;
	assign start_time      = start_q;
	assign completion_time = fin_time_q;
	assign turnaround_time = turn_q;
	assign waiting_time    = wait_q;
	assign last_result     = last_q;

endmodule

// ----- dv/nonpreemptive_priority_scheduler_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nonpreemptive_priority_scheduler: directed job sets, then random sets.
// Depends on nps_pkg and the scheduler RTL; a built-in dispatch predictor checks every result.
module nonpreemptive_priority_scheduler_tb;
	import nps_pkg::*;

	localparam int MAX_JOBS    = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 100;
	localparam int NUM_PHASES  = 4;
	localparam int TAIL_CYCLES = 40;

	// One dispatch record as the block reports it
	typedef struct packed {
		logic [JIDX_W-1:0] jidx;
		logic [TIME_W-1:0] t_start;
		logic [TIME_W-1:0] t_done;
		logic [TIME_W-1:0] t_turn;
		logic [TIME_W-1:0] t_wait;
		logic              last_flag;
	} dispatch_t;

	// Directed request with an optional hand-written result (single-job sets only)
	typedef struct {
		logic [ARR_W-1:0] arr;
		logic [BUR_W-1:0] bur;
		logic [PRI_W-1:0] pri;
		bit               last;
		bit               typed;
		dispatch_t        res;
	} job_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              job_valid = 1'b0;
	logic              job_stall;
	logic [ARR_W-1:0]  arrival_time = '0;
	logic [BUR_W-1:0]  burst_time = '0;
	logic [PRI_W-1:0]  priority_level = '0;
	logic              last_job = 1'b0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [JIDX_W-1:0] job_index;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] completion_time;
	logic [TIME_W-1:0] turnaround_time;
	logic [TIME_W-1:0] waiting_time;
	logic              last_result;

	int  fail_cnt = 0;
	int  gap_pct = 0;
	int  stall_pct = 0;
	bit  hold_arm = 1'b0;
	logic res_hold = 1'b0;

	int gap_by_phase [NUM_PHASES]   = '{0, 53, 0, 37};
	int stall_by_phase [NUM_PHASES] = '{0, 0, 53, 37};

	// Expected dispatches, oldest first
	dispatch_t pending_dispatch [$];

	// Scheduler's view of the loaded set
	logic [ARR_W-1:0] sched_arr [MAX_JOBS];
	logic [BUR_W-1:0] sched_bur [MAX_JOBS];
	logic [PRI_W-1:0] sched_pri [MAX_JOBS];
	bit               sched_done [MAX_JOBS];
	int               sched_cnt = 0;

	job_row_t job_tab [25] = '{
		// lone job at time 0 with the longest burst
		'{16'h0000, 16'hFFFF, 8'h00, 1'b1, 1'b1,
			'{4'd0, 21'd0, 21'd65535, 21'd65535, 21'd0, 1'b1}},
		// lone job arriving last possible tick, zero burst: clock jumps ahead
		'{16'hFFFF, 16'h0000, 8'hFF, 1'b1, 1'b1,
			'{4'd0, 21'd65535, 21'd65535, 21'd0, 21'd0, 1'b1}},
		// full tie on priority and arrival, idle gaps before the first and second dispatch
		'{16'd5, 16'd3, 8'd2, 1'b0, 1'b0, '0},
		'{16'd5, 16'd4, 8'd2, 1'b0, 1'b0, '0},
		'{16'd2, 16'd1, 8'd2, 1'b1, 1'b0, '0},
		// priority order among waiting jobs, then an idle jump
		'{16'd0, 16'd10, 8'd7, 1'b0, 1'b0, '0},
		'{16'd1, 16'd2, 8'd1, 1'b0, 1'b0, '0},
		'{16'd2, 16'd3, 8'd0, 1'b0, 1'b0, '0},
		'{16'd20, 16'd1, 8'd0, 1'b1, 1'b0, '0},
		// sixteen unmarked jobs: a full store starts scheduling on its own
		'{16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
		'{16'h0000, 16'hFFFF, 8'hFF, 1'b0, 1'b0, '0},
		'{16'hAAAA, 16'h5555, 8'hAA, 1'b0, 1'b0, '0},
		'{16'h5555, 16'hAAAA, 8'h55, 1'b0, 1'b0, '0},
		'{16'h0001, 16'h0000, 8'h80, 1'b0, 1'b0, '0},
		'{16'h0001, 16'h0000, 8'h80, 1'b0, 1'b0, '0},
		'{16'h8000, 16'hFFFF, 8'h01, 1'b0, 1'b0, '0},
		'{16'h7FFF, 16'h0001, 8'h01, 1'b0, 1'b0, '0},
		'{16'h0010, 16'hFFFF, 8'h7F, 1'b0, 1'b0, '0},
		'{16'h1234, 16'h00FF, 8'hFE, 1'b0, 1'b0, '0},
		'{16'hF000, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
		'{16'h0F00, 16'h0010, 8'h33, 1'b0, 1'b0, '0},
		'{16'h00F0, 16'hFFFF, 8'hCC, 1'b0, 1'b0, '0},
		'{16'h000F, 16'h0100, 8'h0F, 1'b0, 1'b0, '0},
		'{16'hFFFE, 16'hFFFF, 8'hF0, 1'b0, 1'b0, '0},
		'{16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, '0}
	};

	nonpreemptive_priority_scheduler #(
		.MAX_JOBS(MAX_JOBS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.arrival_time(arrival_time),
		.burst_time(burst_time),
		.priority_level(priority_level),
		.last_job(last_job),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.job_index(job_index),
		.start_time(start_time),
		.completion_time(completion_time),
		.turnaround_time(turnaround_time),
		.waiting_time(waiting_time),
		.last_result(last_result)
	);

	always #6 clk = ~clk;

	// Best ready job at time now: lowest priority value, then earliest arrival, then lowest index
	function automatic int best_ready(logic [TIME_W-1:0] now);
		int pick;
		pick = -1;
		for (int i = 0; i < sched_cnt; i++) begin
			if (sched_done[i] || TIME_W'(sched_arr[i]) > now)
				continue;
			if (pick < 0 || sched_pri[i] < sched_pri[pick] ||
			    (sched_pri[i] == sched_pri[pick] && sched_arr[i] < sched_arr[pick]))
				pick = i;
		end
		return pick;
	endfunction

	// Run the loaded set to completion, queue one dispatch per job, then empty the set
	function automatic int dispatch_set();
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] earliest;
		bit                any;
		int                pick;
		int                n;
		dispatch_t         d;
		now = '0;
		n = 0;
		for (int k = 0; k < sched_cnt; k++) begin
			pick = best_ready(now);
			// nothing ready: jump to the earliest pending arrival
			if (pick < 0) begin
				any = 1'b0;
				earliest = '0;
				for (int i = 0; i < sched_cnt; i++) begin
					if (!sched_done[i] && (!any || TIME_W'(sched_arr[i]) < earliest)) begin
						earliest = TIME_W'(sched_arr[i]);
						any = 1'b1;
					end
				end
				now = earliest;
				pick = best_ready(now);
			end
			if (pick < 0)
				break;
			d.jidx      = JIDX_W'(pick);
			d.t_start   = now;
			d.t_done    = now + TIME_W'(sched_bur[pick]);
			d.t_turn    = d.t_done - TIME_W'(sched_arr[pick]);
			d.t_wait    = now - TIME_W'(sched_arr[pick]);
			d.last_flag = (k == sched_cnt - 1);
			now = d.t_done;
			sched_done[pick] = 1'b1;
			pending_dispatch = {pending_dispatch, d};
			n++;
		end
		sched_cnt = 0;
		for (int i = 0; i < MAX_JOBS; i++)
			sched_done[i] = 1'b0;
		return n;
	endfunction

	// Store an accepted job; a marked or store-filling job triggers the schedule
	function automatic int load_job(logic [ARR_W-1:0] a, logic [BUR_W-1:0] b,
	                                logic [PRI_W-1:0] p, bit l);
		sched_arr[sched_cnt]  = a;
		sched_bur[sched_cnt]  = b;
		sched_pri[sched_cnt]  = p;
		sched_done[sched_cnt] = 1'b0;
		sched_cnt++;
		if (l || sched_cnt >= MAX_JOBS)
			return dispatch_set();
		return 0;
	endfunction

	// Offer one job request after a random gap; returns the number of dispatches it causes
	task automatic offer_job(input logic [ARR_W-1:0] a, input logic [BUR_W-1:0] b,
	                         input logic [PRI_W-1:0] p, input bit l, output int n);
		while ($urandom_range(99) < gap_pct) begin
			job_valid <= 1'b0;
			@(posedge clk);
		end
		job_valid      <= 1'b1;
		arrival_time   <= a;
		burst_time     <= b;
		priority_level <= p;
		last_job       <= l;
		@(posedge clk);
		while (job_stall)
			@(posedge clk);
		n = load_job(a, b, p, l);
	endtask

	// One random job set: mostly small, sometimes a full store with or without the mark
	task automatic offer_random_set(inout int sent);
		int  sz;
		int  arr_span;
		int  bur_span;
		int  pri_span;
		int  n;
		bit  marked;
		bit  l;
		sz = ($urandom_range(7) == 0) ? MAX_JOBS : $urandom_range(1, 6);
		marked = ($urandom_range(1) == 1);
		arr_span = ($urandom_range(2) == 0) ? 65535 : ($urandom_range(1) ? 20 : 300);
		bur_span = ($urandom_range(2) == 0) ? 65535 : ($urandom_range(1) ? 3 : 40);
		pri_span = $urandom_range(1) ? 255 : 3;
		for (int j = 0; j < sz; j++) begin
			l = (j == sz - 1) && (sz < MAX_JOBS || marked);
			offer_job(ARR_W'($urandom_range(arr_span)), BUR_W'($urandom_range(bur_span)),
			          PRI_W'($urandom_range(pri_span)), l, n);
			sent++;
		end
	endtask

	// Sender pauses until every expected dispatch has come out
	task automatic drain_dispatches();
		job_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_dispatch.size() != 0);
	endtask

	// Compare one accepted result with the oldest expectation
	task automatic check_dispatch();
		dispatch_t got;
		dispatch_t want;
		got = '{job_index, start_time, completion_time, turnaround_time, waiting_time,
		        last_result};
		if (pending_dispatch.size() == 0) begin
			$error("unexpected result: job_index %0d start_time %0d", job_index, start_time);
			fail_cnt++;
			return;
		end
		want = pending_dispatch.pop_front();
		if (got.jidx !== want.jidx) begin
			$error("job_index: expected %0d, got %0d", want.jidx, got.jidx);
			fail_cnt++;
		end
		if (got.t_start !== want.t_start) begin
			$error("start_time: expected %0d, got %0d", want.t_start, got.t_start);
			fail_cnt++;
		end
		if (got.t_done !== want.t_done) begin
			$error("completion_time: expected %0d, got %0d", want.t_done, got.t_done);
			fail_cnt++;
		end
		if (got.t_turn !== want.t_turn) begin
			$error("turnaround_time: expected %0d, got %0d", want.t_turn, got.t_turn);
			fail_cnt++;
		end
		if (got.t_wait !== want.t_wait) begin
			$error("waiting_time: expected %0d, got %0d", want.t_wait, got.t_wait);
			fail_cnt++;
		end
		if (got.last_flag !== want.last_flag) begin
			$error("last_result: expected %0d, got %0d", want.last_flag, got.last_flag);
			fail_cnt++;
		end
	endtask

	// Result side: check what is taken at this edge, then pick the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_dispatch();
			res_stall <= res_hold || ($urandom_range(99) < stall_pct);
		end
	end

	// Long receiver hold-off, counted here, so the block backs up into job_stall
	initial begin
		wait (hold_arm);
		@(posedge clk);
		res_hold <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		res_hold <= 1'b0;
	end

	// Stimulus sequence
	initial begin
		int n;
		int sent;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; hand-written results replace the computed one
		foreach (job_tab[r]) begin
			offer_job(job_tab[r].arr, job_tab[r].bur, job_tab[r].pri, job_tab[r].last, n);
			if (job_tab[r].typed && n == 1)
				pending_dispatch[$] = job_tab[r].res;
		end
		drain_dispatches();

		// random sets under each idling mix; the first phase also carries the hold-off
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			gap_pct = gap_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			if (ph == 0)
				hold_arm = 1'b1;
			sent = 0;
			while (sent < RAND_ITEMS / NUM_PHASES)
				offer_random_set(sent);
			drain_dispatches();
		end

		// nothing more may come out
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (fail_cnt == 0)
			$display("nonpreemptive_priority_scheduler verification clean");
		else
			$display("nonpreemptive_priority_scheduler verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(400_000 * 12);
		$display("nonpreemptive_priority_scheduler verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/nps_pkg.sv
hdl/nps_job_mem.sv
hdl/nps_pick_unit.sv
hdl/nonpreemptive_priority_scheduler.sv
dv/nonpreemptive_priority_scheduler_tb.sv
